FILE: rtl/core/drd_pkg.sv
// Shared types and constants for the dictionary record deframer.
`default_nettype none

package drd_pkg;

    // Record layout
    localparam int MaxRecordLen = 256;
    localparam int HeaderBytes  = 5;

    localparam logic [7:0] ByteZero    = 8'h00;
    localparam logic [7:0] ByteNewline = 8'h0A;

    // Result queue sizing: one beat may produce two results
    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = $clog2(FifoDepth + 1);

    typedef enum logic [6:0] {
        PH_START   = 7'b0000001,
        PH_HASH_HI = 7'b0000010,
        PH_HASH_LO = 7'b0000100,
        PH_WORD_HI = 7'b0001000,
        PH_WORD_LO = 7'b0010000,
        PH_NAME    = 7'b0100000,
        PH_HALT    = 7'b1000000
    } t_phase;

    typedef enum logic [2:0] {
        K_CHAR = 3'd0,
        K_DONE = 3'd1,
        K_PAD  = 3'd2,
        K_ERR  = 3'd3,
        K_END  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_char;
        logic [15:0] hash_index;
        logic [15:0] word_index;
        logic [7:0]  name_length;
        logic [8:0]  record_bytes;
        logic        truncated;
        logic        last;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] hash_index;
        logic [15:0] word_index;
        logic [8:0]  byte_count;
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/drd_parse.sv
// Per-beat record parser: next state and up to two results from one stream byte.
`default_nettype none

module drd_parse (
    input  var drd_pkg::t_state  i_state,
    input  wire                  i_eos,
    input  wire [7:0]            i_byte,
    output drd_pkg::t_state      o_state,
    output drd_pkg::t_result     o_res0,
    output drd_pkg::t_result     o_res1,
    output logic [1:0]           o_push_n
);

    function automatic drd_pkg::t_result mk_result(
        drd_pkg::t_kind k, logic [7:0] ch, logic [15:0] hi, logic [15:0] wi,
        logic [7:0] nlen, logic [8:0] rbytes, logic trunc);
        drd_pkg::t_result r;
        r.kind         = k;
        r.name_char    = ch;
        r.hash_index   = hi;
        r.word_index   = wi;
        r.name_length  = nlen;
        r.record_bytes = rbytes;
        r.truncated    = trunc;
        r.last         = 1'b0;
        return r;
    endfunction

    logic             start_now;
    logic [8:0]       next_count;
    logic             is_term;
    drd_pkg::t_result start_res;
    logic             start_has_res;

    assign next_count = i_state.byte_count + 9'd1;
    assign is_term    = (i_byte == drd_pkg::ByteZero) || (i_byte == drd_pkg::ByteNewline);

    always_comb begin
        o_state   = i_state;
        o_res0    = '0;
        o_res1    = '0;
        o_push_n  = 2'd0;
        start_now = 1'b0;
        start_res = '0;
        start_has_res = 1'b0;

        if (i_state.phase == drd_pkg::PH_HALT) begin
            // halted: swallow everything
        end else if (i_eos) begin
            o_res0         = mk_result(drd_pkg::K_END, 8'd0, 16'd0, 16'd0, 8'd0, 9'd0, 1'b0);
            o_push_n       = 2'd1;
            o_state.phase  = drd_pkg::PH_HALT;
        end else begin
            case (i_state.phase)
                drd_pkg::PH_HASH_HI: begin
                    o_state.hash_index = {i_byte, 8'd0};
                    o_state.phase      = drd_pkg::PH_HASH_LO;
                end
                drd_pkg::PH_HASH_LO: begin
                    o_state.hash_index = {i_state.hash_index[15:8], i_byte};
                    o_state.phase      = drd_pkg::PH_WORD_HI;
                end
                drd_pkg::PH_WORD_HI: begin
                    o_state.word_index = {i_byte, 8'd0};
                    o_state.phase      = drd_pkg::PH_WORD_LO;
                end
                drd_pkg::PH_WORD_LO: begin
                    o_state.word_index = {i_state.word_index[15:8], i_byte};
                    o_state.byte_count = 9'(drd_pkg::HeaderBytes);
                    o_state.phase      = drd_pkg::PH_NAME;
                end
                drd_pkg::PH_NAME: begin
                    if (is_term) begin
                        // close the record, then reread the terminator as a start byte
                        o_res0 = mk_result(drd_pkg::K_DONE, 8'd0, i_state.hash_index,
                            i_state.word_index,
                            8'(i_state.byte_count - 9'(drd_pkg::HeaderBytes)),
                            i_state.byte_count, 1'b0);
                        o_push_n  = 2'd1;
                        start_now = 1'b1;
                    end else begin
                        o_state.byte_count = next_count;
                        if (next_count >= 9'(drd_pkg::MaxRecordLen)) begin
                            // limit hit: drop this char and close as truncated
                            o_res0 = mk_result(drd_pkg::K_DONE, 8'd0, i_state.hash_index,
                                i_state.word_index,
                                8'(next_count - 9'(drd_pkg::HeaderBytes + 1)),
                                next_count, 1'b1);
                            o_state.phase = drd_pkg::PH_START;
                        end else begin
                            o_res0 = mk_result(drd_pkg::K_CHAR, i_byte, 16'd0, 16'd0,
                                8'd0, 9'd0, 1'b0);
                        end
                        o_push_n = 2'd1;
                    end
                end
                default: begin
                    start_now = 1'b1;
                end
            endcase
        end

        if (start_now) begin
            if (i_byte == drd_pkg::ByteZero) begin
                o_state.phase = drd_pkg::PH_HASH_HI;
            end else if (i_byte == drd_pkg::ByteNewline) begin
                start_res     = mk_result(drd_pkg::K_PAD, 8'd0, 16'd0, 16'd0, 8'd0, 9'd0, 1'b0);
                start_has_res = 1'b1;
                o_state.phase = drd_pkg::PH_START;
            end else begin
                start_res     = mk_result(drd_pkg::K_ERR, 8'd0, 16'd0, 16'd0, 8'd0, 9'd0, 1'b0);
                start_has_res = 1'b1;
                o_state.phase = drd_pkg::PH_HALT;
            end
            if (start_has_res) begin
                if (o_push_n == 2'd0) begin
                    o_res0 = start_res;
                end else begin
                    o_res1 = start_res;
                end
                o_push_n = o_push_n + 2'd1;
            end
        end

        // flag the final result of this beat
        if (o_push_n == 2'd1) begin
            o_res0.last = 1'b1;
        end else if (o_push_n == 2'd2) begin
            o_res1.last = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/drd_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
`default_nettype none

module drd_fifo (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [1:0]                    i_push_n,
    input  var drd_pkg::t_result         i_data0,
    input  var drd_pkg::t_result         i_data1,
    output logic                         o_room,
    output logic                         o_valid,
    output drd_pkg::t_result             o_data,
    input  wire                          i_ready
);

    drd_pkg::t_result                r_mem [drd_pkg::FifoDepth];
    logic [drd_pkg::PtrW-1:0]        r_wptr;
    logic [drd_pkg::PtrW-1:0]        r_rptr;
    logic [drd_pkg::CntW-1:0]        r_count;
    logic [drd_pkg::PtrW-1:0]        wptr_plus1;
    logic                            pop;

    assign o_valid    = (r_count != '0);
    assign o_data     = r_mem[r_rptr];
    assign pop        = o_valid && i_ready;
    // room for a full two-result beat
    assign o_room     = (r_count <= drd_pkg::CntW'(drd_pkg::FifoDepth - 2));
    assign wptr_plus1 = r_wptr + drd_pkg::PtrW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wptr] <= i_data0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wptr_plus1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + drd_pkg::PtrW'(i_push_n);
            if (pop) begin
                r_rptr <= r_rptr + drd_pkg::PtrW'(1);
            end
            r_count <= r_count + drd_pkg::CntW'(i_push_n) - drd_pkg::CntW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= drd_pkg::CntW'(drd_pkg::FifoDepth))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |->
            ({1'b0, r_count} + (drd_pkg::CntW+1)'(i_push_n) - (drd_pkg::CntW+1)'(pop)
             <= (drd_pkg::CntW+1)'(drd_pkg::FifoDepth)))
        else $error("result queue overflow");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_count == '0))
        else $error("result queue not empty after reset");

endmodule

`default_nettype wire

FILE: rtl/core/dictionary_record_deframer_core.sv
// Top level of the dictionary record deframer: stream ports, parser state, result queue.
//
// Use: feed the raw dictionary byte stream on the slave side, one byte per beat in
// s_tdata with s_tuser low; raise s_tuser for a single end-of-stream beat. Records are
// a zero byte, a big-endian hash index, a big-endian word index and name bytes up to
// a zero or newline. The master side returns one result per beat: m_tuser carries the
// result kind (name char, record done, padding, format error, end of stream), m_tdata
// the payload and m_tlast marks the final result caused by one input beat.
// A taken input beat writes its results into the result queue, which offers them in order.
// Throughput: one input beat per cycle while results drain at one per cycle; a
// newline that closes a record yields two results, a record done and a padding result.
// The parser is a single state update from the state registers and the input beat,
// written straight into a four-entry result queue; s_tready stays high while the queue
// has room for two results, so the input keeps moving while a result waits.
// Reset (synchronous, active low) returns the parser to record start and empties
// the queue. After a format error or end of stream, input beats are still taken but
// produce nothing until the next reset. A stalled receiver holds m_tvalid and the
// payload; s_tready drops once the queue holds more than two results.
`default_nettype none

module dictionary_record_deframer_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave side
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [7:0]   i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tuser,   // [0] kind (1 = end of stream)
    // master side
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [63:0] o_m_tdata,   // [7:0] name_char, [23:8] hash_index,
                                     // [39:24] word_index, [47:40] name_length,
                                     // [56:48] record_bytes, [57] truncated, [63:58] zero
    output logic [2:0]  o_m_tuser,   // [2:0] out_kind
    output logic        o_m_tlast    // last result of the input beat
);

    drd_pkg::t_state   r_state;
    drd_pkg::t_state   n_state;
    drd_pkg::t_result  res0;
    drd_pkg::t_result  res1;
    drd_pkg::t_result  head;
    logic [1:0]        parse_n;
    logic [1:0]        push_n;
    logic              room;
    logic              in_fire;

    assign o_s_tready = room;
    assign in_fire    = i_s_tvalid && room;
    // push nothing into the queue when no beat is taken
    assign push_n     = in_fire ? parse_n : 2'd0;

    drd_parse u_parse (
        .i_state  (r_state),
        .i_eos    (i_s_tuser),
        .i_byte   (i_s_tdata),
        .o_state  (n_state),
        .o_res0   (res0),
        .o_res1   (res1),
        .o_push_n (parse_n)
    );

    // advance the parser once per taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= drd_pkg::PH_START;
            r_state.hash_index <= 16'd0;
            r_state.word_index <= 16'd0;
            r_state.byte_count <= 9'd0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    drd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_data0  (res0),
        .i_data1  (res1),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .o_data   (head),
        .i_ready  (i_m_tready)
    );

    assign o_m_tdata = {6'd0, head.truncated, head.record_bytes, head.name_length,
                        head.word_index, head.hash_index, head.name_char};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == drd_pkg::PH_HALT) |=> (r_state.phase == drd_pkg::PH_HALT))
        else $error("parser left the halted state without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == drd_pkg::PH_HALT) |-> (push_n == 2'd0))
        else $error("halted parser produced a result");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_count <= 9'(drd_pkg::MaxRecordLen))
        else $error("record byte count beyond limit");

endmodule

`default_nettype wire
